### hdl/kstd_pkg.sv
// Shared types, constants and helpers for the key sequence trigger detector.
`default_nettype none

package kstd_pkg;

    localparam int KEY_BITS     = 8;
    localparam int MAX_KEYS     = 8;
    localparam int POS_BITS     = 4;
    localparam int CNT_BITS     = 4;
    localparam int PAT_BITS     = 64;
    localparam int REACT_BITS   = 16;
    localparam int ELAPSED_BITS = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 64;
    localparam int TIME_BITS_DEFAULT = 16;

    localparam int IN_TDATA_BITS  = 32;
    localparam int OUT_TDATA_BITS = 8;

    typedef enum logic [0:0] {
        CMD_KEY  = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_KEY_COUNT      = 2'd0,
        REG_KEY_PATTERN    = 2'd1,
        REG_REACTION_TICKS = 2'd2
    } reg_idx_t;

    // Configuration as seen by the datapath; the count is already clamped.
    typedef struct packed {
        logic [CNT_BITS-1:0]   count;
        logic [PAT_BITS-1:0]   pattern;
        logic [REACT_BITS-1:0] reaction;
    } cfg_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [KEY_BITS-1:0]     key_code;
        logic [ELAPSED_BITS-1:0] elapsed_ticks;
        logic                    pattern_key_held;
    } in_beat_t;

    typedef struct packed {
        logic [POS_BITS-1:0] position;
        logic                lockout;
    } match_state_t;

    typedef struct packed {
        logic                activated;
        logic [POS_BITS-1:0] match_position;
    } out_beat_t;

    function automatic logic [KEY_BITS-1:0] pattern_key(
        input logic [PAT_BITS-1:0] pat,
        input logic [2:0]          idx
    );
        return pat[{idx, 3'b000} +: KEY_BITS];
    endfunction

endpackage

`default_nettype wire

### hdl/key_sequence_trigger_detector_core.sv
// Top level: input beat register, match state, result register and handshakes.
//
//  Channel   Direction  Handshake          Payload (lowest bit first)
//  s_axis    in         s_tvalid/s_tready  tuser: cmd; tdata: key_code, elapsed_ticks,
//                                          pattern_key_held
//  m_axis    out        m_tvalid/m_tready  tdata: activated, match_position
//  cfg       in         cfg_we             cfg_index, cfg_wdata (no read-back)
//
//  Each beat passes through two registers from acceptance to result: the input register,
//  where the step logic updates the match state, and then the result register.
//  A new beat is accepted every cycle while the result side keeps draining.
//  A stalled result holds the input register full; ready then drops on the input side.
//  Reset clears the match state, the lockout, the timer and both valid flags.
`default_nettype none

module key_sequence_trigger_detector_core
#(
    parameter int TIME_BITS = kstd_pkg::TIME_BITS_DEFAULT
)
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    // [7:0] key_code, [23:8] elapsed_ticks, [24] pattern_key_held, [31:25] zero
    input  wire logic [kstd_pkg::IN_TDATA_BITS-1:0]         s_tdata,
    // [0] cmd
    input  wire logic                                       s_tuser,
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    // [0] activated, [4:1] match_position, [7:5] zero
    output logic [kstd_pkg::OUT_TDATA_BITS-1:0]             m_tdata,
    input  wire logic                                       cfg_we,
    input  wire logic [kstd_pkg::CFG_IDX_BITS-1:0]          cfg_index,
    input  wire logic [kstd_pkg::CFG_DATA_BITS-1:0]         cfg_wdata
);

    kstd_pkg::cfg_t         cfg;
    kstd_pkg::in_beat_t     beat_reg;
    kstd_pkg::in_beat_t     beat_next;
    logic                   beat_valid_reg;
    kstd_pkg::match_state_t state_reg;
    kstd_pkg::match_state_t state_next;
    logic [TIME_BITS-1:0]   time_left_reg;
    logic [TIME_BITS-1:0]   time_left_next;
    kstd_pkg::out_beat_t    result_next;
    kstd_pkg::out_beat_t    result_reg;
    logic                   result_valid_reg;
    logic                   advance;
    logic                   fire;

    kstd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kstd_step #(.TIME_BITS(TIME_BITS)) u_step
    (
        .cfg           (cfg),
        .beat          (beat_reg),
        .state_cur     (state_reg),
        .time_left_cur (time_left_reg),
        .state_nxt     (state_next),
        .time_left_nxt (time_left_next),
        .result        (result_next)
    );

    // The result register can take a new beat when empty or being drained.
    assign advance  = !result_valid_reg || m_tready;
    assign fire     = beat_valid_reg && advance;
    assign s_tready = !beat_valid_reg || advance;

    always_comb
    begin
        beat_next.cmd              = kstd_pkg::cmd_t'(s_tuser);
        beat_next.key_code         = s_tdata[7:0];
        beat_next.elapsed_ticks    = s_tdata[23:8];
        beat_next.pattern_key_held = s_tdata[24];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
            time_left_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                beat_valid_reg <= s_tvalid;
            if (advance)
                result_valid_reg <= beat_valid_reg;
            if (fire)
            begin
                state_reg     <= state_next;
                time_left_reg <= time_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            beat_reg <= beat_next;
        if (fire)
            result_reg <= result_next;
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = {3'b000, result_reg.match_position, result_reg.activated};

endmodule

`default_nettype wire

### hdl/kstd_cfg.sv
// Configuration registers with key count clamping.
`default_nettype none

module kstd_cfg
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [kstd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [kstd_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    output kstd_pkg::cfg_t                              cfg
);

    logic [kstd_pkg::CNT_BITS-1:0]   key_count_reg;
    logic [kstd_pkg::PAT_BITS-1:0]   key_pattern_reg;
    logic [kstd_pkg::REACT_BITS-1:0] reaction_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg   <= kstd_pkg::CNT_BITS'(1);
            key_pattern_reg <= '0;
            reaction_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (kstd_pkg::reg_idx_t'(cfg_index))
                kstd_pkg::REG_KEY_COUNT:
                    key_count_reg <= cfg_wdata[kstd_pkg::CNT_BITS-1:0];
                kstd_pkg::REG_KEY_PATTERN:
                    key_pattern_reg <= cfg_wdata[kstd_pkg::PAT_BITS-1:0];
                kstd_pkg::REG_REACTION_TICKS:
                    reaction_reg <= cfg_wdata[kstd_pkg::REACT_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // A count of zero behaves as one, anything above the pattern size as the size.
    always_comb
    begin
        cfg.pattern  = key_pattern_reg;
        cfg.reaction = reaction_reg;
        if (key_count_reg == '0)
            cfg.count = kstd_pkg::CNT_BITS'(1);
        else if (key_count_reg > kstd_pkg::CNT_BITS'(kstd_pkg::MAX_KEYS))
            cfg.count = kstd_pkg::CNT_BITS'(kstd_pkg::MAX_KEYS);
        else
            cfg.count = key_count_reg;
    end

endmodule

`default_nettype wire

### hdl/kstd_step.sv
// Next-state and result logic for one key or tick beat.
`default_nettype none

module kstd_step
#(
    parameter int TIME_BITS = kstd_pkg::TIME_BITS_DEFAULT
)
(
    input  wire kstd_pkg::cfg_t        cfg,
    input  wire kstd_pkg::in_beat_t    beat,
    input  wire kstd_pkg::match_state_t state_cur,
    input  wire logic [TIME_BITS-1:0]  time_left_cur,
    output kstd_pkg::match_state_t     state_nxt,
    output logic [TIME_BITS-1:0]       time_left_nxt,
    output kstd_pkg::out_beat_t        result
);

    logic [2:0]                    cur_idx;
    logic [2:0]                    prev_idx;
    logic [kstd_pkg::KEY_BITS-1:0] cur_key;
    logic [kstd_pkg::KEY_BITS-1:0] prev_key;
    logic [TIME_BITS-1:0]          reload_val;
    logic [TIME_BITS-1:0]          elapsed;
    logic                          full_match;
    logic                          partial;
    logic                          blocked;
    logic                          activated;

    always_comb
    begin
        cur_idx    = state_cur.position[2:0];
        prev_idx   = cur_idx - 3'd1;
        cur_key    = kstd_pkg::pattern_key(cfg.pattern, cur_idx);
        prev_key   = kstd_pkg::pattern_key(cfg.pattern, prev_idx);
        reload_val = TIME_BITS'(cfg.reaction);
        elapsed    = TIME_BITS'(beat.elapsed_ticks);
        full_match = (state_cur.position >= cfg.count);
        partial    = (state_cur.position != '0);
        blocked    = state_cur.lockout && beat.pattern_key_held;

        state_nxt     = state_cur;
        time_left_nxt = time_left_cur;
        activated     = 1'b0;

        unique case (beat.cmd)
            kstd_pkg::CMD_KEY:
            begin
                if (!full_match)
                begin
                    if (cur_key == beat.key_code)
                    begin
                        state_nxt.position = state_cur.position + kstd_pkg::POS_BITS'(1);
                        time_left_nxt      = reload_val;
                    end
                    else if (partial && (prev_key != beat.key_code))
                    begin
                        state_nxt.position = '0;
                        time_left_nxt      = reload_val;
                    end
                end
            end
            kstd_pkg::CMD_TICK:
            begin
                if (!blocked)
                begin
                    state_nxt.lockout = 1'b0;
                    if (full_match)
                    begin
                        state_nxt.position = '0;
                        state_nxt.lockout  = 1'b1;
                        activated          = 1'b1;
                    end
                    else if (partial)
                    begin
                        if (elapsed >= time_left_cur)
                        begin
                            state_nxt.position = '0;
                            time_left_nxt      = reload_val;
                        end
                        else
                        begin
                            time_left_nxt = time_left_cur - elapsed;
                        end
                    end
                end
            end
            default:
                ;
        endcase

        result.activated      = activated;
        result.match_position = state_nxt.position;
    end

endmodule

`default_nettype wire

### sim/tb_key_sequence_trigger_detector_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the key sequence trigger detector core.

module tb_key_sequence_trigger_detector_core;

    localparam logic [kstd_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [kstd_pkg::IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                                s_tuser = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [kstd_pkg::OUT_TDATA_BITS-1:0] m_tdata;
    logic                                cfg_we = 1'b0;
    logic [kstd_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [kstd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    // Register copies and match state, at their reset values.
    logic [kstd_pkg::CNT_BITS-1:0]   cfg_count = 4'd1;
    logic [kstd_pkg::PAT_BITS-1:0]   cfg_pattern = '0;
    logic [kstd_pkg::REACT_BITS-1:0] cfg_reaction = '0;
    logic [kstd_pkg::POS_BITS-1:0]   match_pos = '0;
    logic [15:0]                     reaction_left = '0;
    logic                            locked_out = 1'b0;

    kstd_pkg::out_beat_t expected_reports[$];
    int beats_accepted = 0;
    int items_sent = 0;
    int fail_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    key_sequence_trigger_detector_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [3:0] active_length();
        if (cfg_count == 0)
            return 4'd1;
        if (cfg_count > kstd_pkg::MAX_KEYS)
            return 4'(kstd_pkg::MAX_KEYS);
        return cfg_count;
    endfunction

    function automatic logic [7:0] key_at(input logic [3:0] idx);
        return 8'(cfg_pattern >> (8 * idx[2:0]));
    endfunction

    // Advances the match state by one beat and returns the report it produces.
    function automatic kstd_pkg::out_beat_t advance_matcher(input kstd_pkg::in_beat_t b);
        kstd_pkg::out_beat_t r;
        logic [3:0]          len;
        logic                blocked;
        len = active_length();
        blocked = 1'b0;
        r.activated = 1'b0;
        if (b.cmd == kstd_pkg::CMD_KEY)
        begin
            if (match_pos < len)
            begin
                if (key_at(match_pos) == b.key_code)
                begin
                    match_pos = match_pos + 4'd1;
                    reaction_left = cfg_reaction;
                end
                else if (match_pos != 0 && key_at(match_pos - 4'd1) != b.key_code)
                begin
                    match_pos = '0;
                    reaction_left = cfg_reaction;
                end
            end
        end
        else
        begin
            if (locked_out)
            begin
                if (b.pattern_key_held)
                    blocked = 1'b1;
                else
                    locked_out = 1'b0;
            end
            if (!blocked)
            begin
                if (match_pos >= len)
                begin
                    match_pos = '0;
                    locked_out = 1'b1;
                    r.activated = 1'b1;
                end
                else if (match_pos != 0)
                begin
                    if (b.elapsed_ticks >= reaction_left)
                    begin
                        match_pos = '0;
                        reaction_left = cfg_reaction;
                    end
                    else
                        reaction_left = reaction_left - b.elapsed_ticks;
                end
            end
        end
        r.match_position = match_pos;
        return r;
    endfunction

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : scoreboard
        kstd_pkg::in_beat_t  taken;
        kstd_pkg::out_beat_t want;
        kstd_pkg::out_beat_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.activated = m_tdata[0];
                got.match_position = m_tdata[4:1];
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected result beat: tdata %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.activated !== want.activated)
                    begin
                        $error("activated: expected %0d, got %0d", want.activated,
                               got.activated);
                        fail_count++;
                    end
                    if (got.match_position !== want.match_position)
                    begin
                        $error("match_position: expected %0d, got %0d",
                               want.match_position, got.match_position);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                taken.cmd = kstd_pkg::cmd_t'(s_tuser);
                taken.key_code = s_tdata[7:0];
                taken.elapsed_ticks = s_tdata[23:8];
                taken.pattern_key_held = s_tdata[24];
                expected_reports.insert(expected_reports.size(), advance_matcher(taken));
                beats_accepted++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_beat(input kstd_pkg::in_beat_t b);
        int seen;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= b.cmd;
        s_tdata <= {7'b0, b.pattern_key_held, b.elapsed_ticks, b.key_code};
        seen = beats_accepted;
        @(negedge clk);
        while (beats_accepted == seen)
            @(negedge clk);
        items_sent++;
    endtask

    // Fields that the command does not use still carry random values.
    task automatic send_key(input logic [7:0] key);
        kstd_pkg::in_beat_t b;
        b.cmd = kstd_pkg::CMD_KEY;
        b.key_code = key;
        b.elapsed_ticks = 16'($urandom);
        b.pattern_key_held = 1'($urandom);
        send_beat(b);
    endtask

    task automatic send_tick(input logic [15:0] elapsed, input logic held);
        kstd_pkg::in_beat_t b;
        b.cmd = kstd_pkg::CMD_TICK;
        b.key_code = 8'($urandom);
        b.elapsed_ticks = elapsed;
        b.pattern_key_held = held;
        send_beat(b);
    endtask

    task automatic hold_until_results_in();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [kstd_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [kstd_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            kstd_pkg::REG_KEY_COUNT:      cfg_count = value[kstd_pkg::CNT_BITS-1:0];
            kstd_pkg::REG_KEY_PATTERN:    cfg_pattern = value;
            kstd_pkg::REG_REACTION_TICKS: cfg_reaction = value[kstd_pkg::REACT_BITS-1:0];
            default:                      ;
        endcase
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_elapsed();
        if ($urandom_range(99) < 80)
            return 16'($urandom_range(0, cfg_reaction >> 2));
        return 16'($urandom);
    endfunction

    // A mostly well-formed run through the pattern, with repeats, ticks and strays.
    task automatic play_sequence();
        int len;
        int k;
        len = active_length();
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < 6)
                send_key(8'($urandom));
            send_key(key_at(4'(k)));
            if ($urandom_range(99) < 15)
                send_key(key_at(4'(k)));
            if ($urandom_range(99) < 25)
                send_tick(pick_elapsed(), 1'($urandom));
        end
        if ($urandom_range(99) < 30)
            send_key(8'($urandom));
        send_tick(pick_elapsed(), 1'($urandom));
        while ($urandom_range(99) < 50)
            send_tick(pick_elapsed(), 1'b1);
        send_tick(pick_elapsed(), 1'b0);
    endtask

    task automatic send_noise();
        if ($urandom_range(1))
            send_tick(16'($urandom), 1'($urandom));
        else
            send_key(8'($urandom));
    endtask

    task automatic test_power_on_defaults();
        // One key of code zero is the whole sequence after reset.
        send_key(8'h00);
        send_key(8'hFF);
        send_tick(16'h0000, 1'b1);
        send_tick(16'h0000, 1'b1);
        send_tick(16'hFFFF, 1'b0);
        hold_until_results_in();
    endtask

    task automatic test_sequence_and_timeout();
        write_register(REG_SPARE, '1);
        write_register(kstd_pkg::REG_KEY_COUNT, 64'd3);
        write_register(kstd_pkg::REG_KEY_PATTERN, 64'h0000_0000_0080_00FF);
        write_register(kstd_pkg::REG_REACTION_TICKS, 64'hFFFF);
        send_key(8'hFF);
        send_key(8'hFF);
        send_key(8'h00);
        send_tick(16'hFFFE, 1'b1);
        send_key(8'h80);
        send_tick(16'h0000, 1'b0);
        send_key(8'h13);
        send_key(8'hFF);
        send_key(8'h77);
        send_key(8'hFF);
        send_tick(16'hFFFF, 1'b0);
        hold_until_results_in();
    endtask

    task automatic test_count_limits();
        // A count of zero acts as one key.
        write_register(kstd_pkg::REG_KEY_COUNT, 64'd0);
        send_key(8'hFF);
        send_tick(16'h0001, 1'b0);
        send_tick(16'h0001, 1'b0);
        hold_until_results_in();
        write_register(kstd_pkg::REG_KEY_COUNT, 64'd15);
        write_register(kstd_pkg::REG_KEY_PATTERN, 64'h0123_4567_89AB_CDEF);
        send_key(8'hEF);
        send_key(8'hCD);
        hold_until_results_in();
        // Lowering the count below the position turns it into a full match.
        write_register(kstd_pkg::REG_KEY_COUNT, 64'd1);
        send_key(8'hEF);
        send_tick(16'h0000, 1'b1);
        send_tick(16'h0000, 1'b0);
        hold_until_results_in();
    endtask

    task automatic test_random_traffic();
        logic [3:0]  counts[8];
        logic [63:0] pattern;
        logic [7:0]  alphabet[2];
        int p;
        int b;
        int half_mark;
        int phase_end;
        counts = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8, 4'd2};
        for (p = 0; p < 8; p++)
        begin
            hold_until_results_in();
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 60;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 60;
                end
                default:
                begin
                    send_idle_pct = 13;
                    stall_pct = 13;
                end
            endcase
            pattern = {$urandom, $urandom};
            // Half the phases draw keys from two codes, so repeats are common.
            if (p % 2 == 1)
            begin
                alphabet[0] = 8'($urandom);
                alphabet[1] = 8'($urandom);
                for (b = 0; b < 8; b++)
                    pattern[8*b +: 8] = alphabet[$urandom_range(1)];
            end
            write_register(kstd_pkg::REG_KEY_COUNT, 64'(counts[p]));
            write_register(kstd_pkg::REG_KEY_PATTERN, pattern);
            case (p)
                0, 7:
                    write_register(kstd_pkg::REG_REACTION_TICKS, 64'd0);
                1, 4:
                    write_register(kstd_pkg::REG_REACTION_TICKS, 64'hFFFF);
                2, 5:
                    write_register(kstd_pkg::REG_REACTION_TICKS,
                                   64'($urandom_range(1, 50)));
                default:
                    write_register(kstd_pkg::REG_REACTION_TICKS,
                                   64'($urandom_range(0, 65535)));
            endcase
            if ($urandom_range(1))
                write_register(REG_SPARE, {$urandom, $urandom});
            half_mark = items_sent + 78;
            phase_end = items_sent + 156;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(99) < 75)
                    play_sequence();
                else
                    send_noise();
                if (half_mark != 0 && items_sent >= half_mark)
                begin
                    hold_until_results_in();
                    half_mark = 0;
                end
            end
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_power_on_defaults();
        test_sequence_and_timeout();
        test_count_limits();
        test_random_traffic();
        hold_until_results_in();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
